// File: hw/rtl/button_macro_sequencer_assert.svh
// Assertion macros shared by the macro sequencer RTL.
// Included by modules that check their own control logic.
`ifndef BUTTON_MACRO_SEQUENCER_ASSERT_SVH
`define BUTTON_MACRO_SEQUENCER_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define BMS_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication
`define BMS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// File: hw/rtl/bms_pkg.sv
// Package for the macro sequencer: field types, state codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package bms_pkg;
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_MACRO = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;
    localparam logic [0:0] CFG_SHARED_PIN = 1'd0;
    localparam logic [0:0] CFG_DEFAULT_HOLD = 1'd1;
    localparam logic [31:0] DEBOUNCE_MS = 32'd5;
    localparam int DPAD_SHIFT = 16;
    localparam logic [3:0] NONE_SEL = 4'd8;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] gpio_levels;
        logic [31:0] buttons_in;
        logic [3:0]  dpad_in;
        logic [31:0] now_ms;
        logic [2:0]  macro_sel;
        logic [4:0]  step_sel;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
    } t_in_item;

    typedef struct packed {
        logic [31:0] buttons_out;
        logic [3:0]  dpad_out;
        logic        running;
        logic [3:0]  active_macro;
    } t_out_item;

    typedef struct packed {
        logic [0:0]  index;
        logic [31:0] data;
    } t_cfg_item;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_FETCH, ST_EVAL, ST_STEP, ST_OUT
    } t_state;
endpackage

// File: hw/rtl/bms_if.sv
// Valid/ready channel interfaces for the macro sequencer.
// Depends on bms_pkg.
`timescale 1ns / 1ps
interface bms_in_if;
    logic valid;
    logic ready;
    bms_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bms_out_if;
    logic valid;
    logic ready;
    bms_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bms_cfg_if;
    logic valid;
    logic ready;
    bms_pkg::t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/bms_step_mem.sv
// Step table storage: button mask, duration and wait per step slot.
// No dependencies; registered read port.
`timescale 1ns / 1ps
module bms_step_mem #(
    parameter int DEPTH = 256,
    parameter int AW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [95:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [95:0]   o_rdata
);
    logic [95:0] r_mem [DEPTH];
    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
    end
    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hw/rtl/button_macro_sequencer.sv
// Button macro sequencer top level: sequencer, macro table and step store.
// Depends on bms_pkg, bms_if, bms_step_mem and the assertion header.
//
// A tick beat keeps the block busy after it is accepted. The scan checks one
// macro per cycle through the shared trigger-compare unit, up to MACRO_COUNT
// macros. It stops at the first hit, and it checks no macro while a
// non-interruptible macro plays. Then come the step store read, evaluation, a
// read of the hold time of a newly entered step, and the result. A write beat
// goes straight to the result after acceptance. The block accepts no beat until
// the result beat has left the output register.
// Configuration writes are taken at any time; no clearing pass.
`timescale 1ns / 1ps
`include "button_macro_sequencer_assert.svh"
module button_macro_sequencer #(
    parameter int MACRO_COUNT = 8,
    parameter int STEP_COUNT = 32,
    parameter int PIN_COUNT = 30
) (
    input logic  i_clk,
    input logic  i_rst_n,
    bms_in_if.sink    in_ch,
    bms_out_if.source out_ch,
    bms_cfg_if.sink   cfg_ch
);
    import bms_pkg::*;
    localparam int MW = (MACRO_COUNT > 1) ? $clog2(MACRO_COUNT) : 1;
    localparam int SW = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
    localparam int AW = MW + SW;

    t_state r_state, n_state;
    t_in_item r_item;
    logic [4:0]  r_shared_pin;
    logic [15:0] r_default_hold;
    logic [48:0] r_macro [MACRO_COUNT];
    logic [3:0]  r_active;
    logic [5:0]  r_step;
    logic r_run, r_held, r_pressed, r_prev;
    logic [31:0] r_step_start, r_hold, r_deb;
    logic [MW:0] r_scan;
    logic        r_abort;
    logic        r_reload;
    t_out_item   r_out;
    logic        r_out_valid;
    logic [95:0] w_rdata;
    logic [31:0] w_pins;
    logic [31:0] sum_hold;

    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shared_pin <= '0;
            r_default_hold <= 16'd50;
        end else if (cfg_ch.valid) begin
            if (cfg_ch.data.index == CFG_SHARED_PIN) r_shared_pin <= cfg_ch.data.data[4:0];
            else r_default_hold <= cfg_ch.data.data[15:0];
        end
    end

    assign in_ch.ready = (r_state == ST_IDLE) && !r_out_valid;
    assign w_pins = ~r_item.gpio_levels;

    // shared trigger test unit, selected macro chosen by sel
    function automatic logic f_trig(input logic [48:0] s, input logic [31:0] pins,
                                    input logic [31:0] btn, input logic [3:0] dp,
                                    input logic [4:0] sp);
        logic [31:0] t;
        t = s[31:0];
        if (s[33]) return pins[sp] && (((btn & t) != 0) || ((dp & t[19:16]) != 0));
        return pins[s[42:38]];
    endfunction

    logic [48:0] w_scan_set;
    logic w_scan_ok;
    logic [MW-1:0] w_scan_idx;
    assign w_scan_idx = r_scan[MW-1:0];
    assign w_scan_set = r_macro[w_scan_idx];
    assign w_scan_ok = w_scan_set[32] && !(w_scan_set[33] && w_scan_set[31:0] == 0)
        && !(!w_scan_set[33] && 32'(w_scan_set[42:38]) >= PIN_COUNT)
        && f_trig(w_scan_set, w_pins, r_item.buttons_in, r_item.dpad_in, r_shared_pin);

    logic w_act_ok;
    logic [MW-1:0] w_act_idx;
    assign w_act_ok = 32'(r_active) < MACRO_COUNT;
    assign w_act_idx = r_active[MW-1:0];

    // step store
    logic w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    assign w_we = in_ch.valid && in_ch.ready && in_ch.data.op == OP_STEP
        && 32'(in_ch.data.macro_sel) < MACRO_COUNT && 32'(in_ch.data.step_sel) < STEP_COUNT;
    assign w_waddr = {in_ch.data.macro_sel[MW-1:0], in_ch.data.step_sel[SW-1:0]};
    assign w_raddr = {w_act_idx, r_step[SW-1:0]};
    bms_step_mem #(.DEPTH(MACRO_COUNT * STEP_COUNT), .AW(AW)) u_mem (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr),
        .i_wdata({in_ch.data.word_c, in_ch.data.word_b, in_ch.data.word_a}),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_ch.valid && in_ch.ready)
                n_state = (in_ch.data.op == OP_TICK) ? ST_SCAN : ST_OUT;
            ST_SCAN: if (32'(r_scan) >= MACRO_COUNT - 1 || w_scan_ok
                         || !(!w_act_ok || r_macro[w_act_idx][36])) n_state = ST_FETCH;
            ST_FETCH: n_state = ST_EVAL;
            ST_EVAL:  n_state = ST_STEP;
            ST_STEP:  n_state = ST_OUT;
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // datapath of the tick evaluation, one beat in ST_EVAL
    logic [3:0] e_active; logic [5:0] e_step;
    logic e_run, e_held, e_pressed, e_prev, e_reload;
    logic [31:0] e_ss, e_hold, e_deb, e_btn; logic [3:0] e_dp;
    always_comb begin
        logic [16:0] f; logic [31:0] t, dur, sum32, el; logic [32:0] sum;
        logic [1:0] typ; logic [5:0] cnt; logic pr, held, adv, loopable, done;
        logic [48:0] s;
        e_active = r_active; e_step = r_step; e_run = r_run; e_held = r_held;
        e_pressed = r_pressed; e_prev = r_prev; e_ss = r_step_start; e_hold = r_hold;
        e_deb = r_deb; e_btn = r_item.buttons_in; e_dp = r_item.dpad_in;
        e_reload = 1'b0;
        pr = 1'b0; held = r_held; adv = 1'b0; loopable = 1'b0; el = '0;
        s = r_macro[w_act_idx]; f = s[48:32]; t = s[31:0];
        typ = f[3:2]; cnt = f[16:11];
        if (32'(cnt) > STEP_COUNT) cnt = 6'(STEP_COUNT);
        sum = {1'b0, w_rdata[63:32]} + {1'b0, w_rdata[95:64]};
        sum32 = sum[32] ? '1 : sum[31:0];
        if (sum32 == 0) sum32 = {16'd0, r_default_hold};
        if (32'(r_step) >= STEP_COUNT) begin
            dur = '0; sum32 = {16'd0, r_default_hold};
        end else dur = w_rdata[63:32];
        done = !w_act_ok || r_abort;
        if (!done) begin
            pr = f_trig(s, w_pins, r_item.buttons_in, r_item.dpad_in, r_shared_pin);
            e_pressed = pr;
            if (!r_run && pr && r_deb == 0) begin
                e_deb = r_item.now_ms; done = 1'b1;
            end else if (r_deb != 0) begin
                if (r_item.now_ms - r_deb > DEBOUNCE_MS) e_deb = '0;
                else done = 1'b1;
            end
        end
        if (!done) begin
            held = r_held;
            if (!r_run) begin
                if (typ == 2'd0 || typ == 2'd2) held = r_prev && !pr;
                else if (typ == 2'd1) held = pr;
            end else begin
                if (typ == 2'd2 && r_prev && !pr) held = 1'b0;
                else if (typ == 2'd1) held = pr;
            end
            e_prev = pr;
            if (!r_run && held) begin
                e_run = 1'b1; e_ss = r_item.now_ms; e_hold = sum32;
            end
            e_held = held;
            if (!e_run) done = 1'b1;
            else if (!held && f[4]) begin
                e_active = NONE_SEL; e_run = 1'b0; e_prev = 1'b0; e_ss = '0; done = 1'b1;
            end
        end
        if (!done) begin
            if (f[5]) begin
                e_btn = '0; e_dp = '0;
            end else begin
                if (f[1]) begin
                    e_dp = e_dp & ~t[19:16]; e_btn = e_btn & ~t;
                end
                // interrupted by other pad input: the masked pad still goes out
                if (f[4] && (e_btn != 0 || e_dp != 0)) begin
                    e_active = NONE_SEL; e_run = 1'b0; e_prev = 1'b0; e_ss = '0;
                    done = 1'b1;
                end
            end
        end
        if (!done) begin
            el = r_item.now_ms - e_ss;
            if (el <= dur && 32'(r_step) < STEP_COUNT) begin
                e_dp = e_dp | w_rdata[19:16]; e_btn = e_btn | w_rdata[31:0];
            end
            if (el >= e_hold) begin
                e_ss = r_item.now_ms; e_step = r_step + 6'd1; adv = 1'b1;
            end
            if (e_step >= cnt) begin
                e_step = '0;
                loopable = (typ == 2'd1 || typ == 2'd2);
                held = e_held && loopable;
                e_held = held; e_run = held;
                if (!held) e_active = NONE_SEL;
                if (loopable && !held) begin
                    e_ss = '0; e_hold = {16'd0, r_default_hold};
                end
            end
            // hold of the new step is loaded in ST_OUT after a fresh read in ST_STEP
            e_reload = adv && e_run && (e_active != NONE_SEL);
        end
    end

    // registers of the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_active <= NONE_SEL; r_step <= '0;
            r_run <= 1'b0; r_held <= 1'b0; r_pressed <= 1'b0; r_prev <= 1'b0;
            r_step_start <= '0; r_hold <= '0; r_deb <= '0;
            r_out_valid <= 1'b0; r_scan <= '0; r_abort <= 1'b0; r_reload <= 1'b0;
            for (int i = 0; i < MACRO_COUNT; i++) r_macro[i] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT) r_out_valid <= 1'b1;
            else if (out_ch.ready) r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: if (in_ch.valid && in_ch.ready) begin
                    r_item <= in_ch.data; r_scan <= '0;
                    r_abort <= 1'b0;
                    if (in_ch.data.op == OP_MACRO && 32'(in_ch.data.macro_sel) < MACRO_COUNT)
                        r_macro[in_ch.data.macro_sel[MW-1:0]] <=
                            {in_ch.data.word_b[16:0], in_ch.data.word_a};
                end
                ST_SCAN: if (!(!w_act_ok || r_macro[w_act_idx][36])) begin
                    // active and not interruptible: no scan
                end else if (w_scan_ok || 32'(r_scan) >= MACRO_COUNT - 1) begin
                    if (w_scan_ok) r_pressed <= 1'b1;
                    if (!w_act_ok && !w_scan_ok) r_abort <= 1'b1;
                    else if (w_act_ok && w_scan_ok && 4'(w_scan_idx) != r_active) begin
                        r_active <= NONE_SEL; r_run <= 1'b0; r_prev <= 1'b0;
                        r_step_start <= '0; r_abort <= 1'b1;
                    end else if (w_scan_ok && !r_run) begin
                        r_active <= 4'(w_scan_idx); r_step_start <= '0;
                    end
                end else r_scan <= r_scan + 1'b1;
                ST_EVAL: begin
                    r_active <= e_active; r_step <= e_step; r_run <= e_run;
                    r_held <= e_held; r_pressed <= e_pressed; r_prev <= e_prev;
                    r_step_start <= e_ss; r_deb <= e_deb;
                    r_out.buttons_out <= e_btn; r_out.dpad_out <= e_dp;
                    r_hold <= e_hold;
                    r_reload <= e_reload;
                end
                ST_OUT: begin
                    r_out.running <= r_run; r_out.active_macro <= r_active;
                    if (r_item.op != OP_TICK || r_abort) begin
                        r_out.buttons_out <= r_item.buttons_in;
                        r_out.dpad_out <= r_item.dpad_in;
                    end
                    if (r_reload) begin
                        r_hold <= sum_hold; r_reload <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // hold time of the newly entered step, read from the store in ST_STEP
    always_comb begin
        logic [32:0] sm;
        sm = {1'b0, w_rdata[63:32]} + {1'b0, w_rdata[95:64]};
        sum_hold = sm[32] ? '1 : sm[31:0];
        if (sum_hold == 0 || 32'(r_step) >= STEP_COUNT) sum_hold = {16'd0, r_default_hold};
    end

    assign out_ch.valid = r_out_valid;
    assign out_ch.data = r_out;

    `BMS_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_state != ST_IDLE, !in_ch.ready)
    `BMS_ASSERT_IMP(a_run_has_macro, i_clk, i_rst_n, r_run && r_state == ST_IDLE,
                    r_active != NONE_SEL)
    `BMS_ASSERT_NEXT(a_out_then_idle, i_clk, i_rst_n, r_state == ST_OUT,
                     r_state == ST_IDLE && r_out_valid)
endmodule
